FILE: rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, sizes and codes for the double-ended queue and its cells.
// ----------------------------------------------------------------------------
package deq_pkg;

  // queue geometry
  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int DATA_W = 32;

  // operation codes carried on the input beat
  localparam logic [2:0] FUNC_INS_FRONT = 3'd0;
  localparam logic [2:0] FUNC_INS_REAR  = 3'd1;
  localparam logic [2:0] FUNC_DEL_FRONT = 3'd2;
  localparam logic [2:0] FUNC_DEL_REAR  = 3'd3;
  localparam logic [2:0] FUNC_DISPLAY   = 3'd4;

  // status codes of a result beat
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // control states
  typedef enum logic {
    ST_IDLE,
    ST_DISPLAY
  } deq_state_t;

  // what every cell does when clocked
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_REAR,
    CELL_POP_FRONT,
    CELL_ROTATE
  } cell_op_t;

  // command broadcast to the whole chain
  typedef struct packed {
    cell_op_t          op;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] data;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One storage position of the queue chain; takes its value from a neighbor,
// from the broadcast data, or holds, as the broadcast command asks.
// ----------------------------------------------------------------------------
module deq_cell (
  input  logic                      clk,
  input  deq_pkg::cell_ctrl_t       ctrl,
  input  logic [deq_pkg::IDX_W-1:0] idx,
  input  logic [deq_pkg::DATA_W-1:0] left_val,
  input  logic [deq_pkg::DATA_W-1:0] right_val,
  output logic [deq_pkg::DATA_W-1:0] val
);
  import deq_pkg::*;

  logic [CNT_W-1:0]  pos;
  logic [DATA_W-1:0] val_next;

  assign pos = CNT_W'(idx);

  // pick the new content of this position
  always_comb begin
    val_next = val;
    case (ctrl.op)
      CELL_PUSH_FRONT: begin
        if (pos == '0) val_next = ctrl.data;
        else           val_next = left_val;
      end
      CELL_PUSH_REAR: begin
        if (pos == ctrl.count) val_next = ctrl.data;
      end
      CELL_POP_FRONT: begin
        val_next = right_val;
      end
      CELL_ROTATE: begin
        // front value wraps round to the rear position
        if (pos == ctrl.count - CNT_W'(1))     val_next = ctrl.data;
        else if (pos < ctrl.count - CNT_W'(1)) val_next = right_val;
      end
      default: val_next = val;
    endcase
  end

  // storage, no reset: positions beyond the fill count are never read
  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

FILE: rtl/core/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values built as a chain of cells.
// ----------------------------------------------------------------------------
// Values sit in a row of DEPTH cells with the front always in cell 0. An
// insert or delete gives one status beat; inserting at the front shifts
// the whole row one cell toward the rear, deleting at the front shifts it
// one cell toward the front. A display first takes the command and then
// sends one stored value per cycle while the output beat is not stalled:
// each time the front cell is sent out and the row rotates one place, so
// after the last value it is back in order. The input is held off until
// the last value is sent, also while the output beat is stalled. A display
// of an empty queue, like an insert into a full one or a delete from an
// empty one, gives a single beat. Unused operation codes are taken and
// give no beat. A new input beat is taken whenever no display is running
// and the output register is free or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic [2:0]  s_tuser,   // func[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // item[31:0]
  output logic [2:0]  m_tuser,   // status[1:0], has_item[2]
  output logic        m_tlast
);
  import deq_pkg::*;

  deq_state_t        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  remain, remain_next;
  logic              out_free;
  logic              in_beat;
  logic              out_load;
  logic [1:0]        out_status;
  logic [DATA_W-1:0] out_item;
  logic              out_has_item;
  logic              out_last;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] cell_val [DEPTH];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign in_beat  = s_tvalid && s_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_beat && s_tuser == FUNC_DISPLAY && count != '0) state_next = ST_DISPLAY;
      end
      ST_DISPLAY: begin
        if (out_free && remain == CNT_W'(1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // chain command, fill count and result beat
  always_comb begin
    ctrl.op      = CELL_HOLD;
    ctrl.count   = count;
    ctrl.data    = s_tdata;
    count_next   = count;
    remain_next  = remain;
    out_load     = 1'b0;
    out_status   = STAT_OK;
    out_item     = '0;
    out_has_item = 1'b0;
    out_last     = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          unique case (s_tuser) inside
            FUNC_INS_FRONT, FUNC_INS_REAR: begin
              out_load = 1'b1;
              if (count == CNT_W'(DEPTH)) begin
                out_status = STAT_FULL;
              end else begin
                ctrl.op    = (s_tuser == FUNC_INS_FRONT) ? CELL_PUSH_FRONT : CELL_PUSH_REAR;
                count_next = count + CNT_W'(1);
              end
            end
            FUNC_DEL_FRONT, FUNC_DEL_REAR: begin
              out_load = 1'b1;
              if (count == '0) begin
                out_status = STAT_EMPTY;
              end else begin
                if (s_tuser == FUNC_DEL_FRONT) ctrl.op = CELL_POP_FRONT;
                count_next = count - CNT_W'(1);
              end
            end
            FUNC_DISPLAY: begin
              if (count == '0) begin
                out_load   = 1'b1;
                out_status = STAT_EMPTY;
              end else begin
                remain_next = count;
              end
            end
            default: begin
              // unused code: taken, no beat
            end
          endcase
        end
      end
      ST_DISPLAY: begin
        if (out_free) begin
          ctrl.op      = CELL_ROTATE;
          ctrl.data    = cell_val[0];
          out_load     = 1'b1;
          out_item     = cell_val[0];
          out_has_item = 1'b1;
          out_last     = (remain == CNT_W'(1));
          remain_next  = remain - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      remain   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      remain <= remain_next;
      if (out_load)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_item;
      m_tuser <= {out_has_item, out_status};
      m_tlast <= out_last;
    end
  end

  // chain of storage cells, front in cell 0
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;
    if (g == 0) begin : g_first
      assign left_in = ctrl.data;
    end else begin : g_mid_l
      assign left_in = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_in = ctrl.data;
    end else begin : g_mid_r
      assign right_in = cell_val[g+1];
    end
    deq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .idx       (IDX_W'(g)),
      .left_val  (left_in),
      .right_val (right_in),
      .val       (cell_val[g])
    );
  end

endmodule

FILE: dv/tb_double_ended_queue.sv
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking stream testbench for the bounded double-ended queue.
// ----------------------------------------------------------------------------
// A stimulus queue is filled up front: a short directed run over the empty,
// full and unused-code corners, then random runs biased toward filling,
// draining or mixing the queue. A clocked driver offers the commands and a
// clocked monitor mirrors the queue contents for every accepted beat, keeps
// the beats it expects and compares each output beat field by field. Both
// ends idle at random rates that change over the run, and one long output
// stall forces the block to hold off its input.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  // unused operation codes, taken without any output beat
  localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FUNC_SPARE_MID   = 3'd6;
  localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

  localparam int RANDOM_OPS   = 440;
  localparam int RUN_LEN      = 24;
  localparam int LONG_STALL   = 300;
  localparam int DRAIN_CYCLES = 50;
  localparam int CYCLE_LIMIT  = 400000;

  // run biases for the random part
  typedef enum logic [1:0] {
    BIAS_FILL,
    BIAS_DRAIN,
    BIAS_MIXED
  } run_bias_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] value;
  } deq_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] item;
    logic        has_item;
    logic        last;
  } deq_beat_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  // mirror of the queue contents
  logic [31:0] mirror_slots [DEPTH];
  int unsigned mirror_front = 0;
  int unsigned mirror_count = 0;

  deq_cmd_t  pending_cmds [$];
  deq_beat_t awaited_beats [$];

  int  cmd_total    = 0;
  int  beats_in     = 0;
  int  fail_count   = 0;
  int  cycle_count  = 0;
  int  send_idle    = 25;
  int  recv_idle    = 79;
  int  stall_left   = 0;
  bit  stall_req    = 1'b0;
  bit  beat_taken   = 1'b0;

  double_ended_queue u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one command to the mirror and queue up the beats it gives
  function automatic void apply_deque_op(input logic [2:0] func, input logic [31:0] value);
    deq_beat_t beat;
    beat = '{status: STAT_OK, item: '0, has_item: 1'b0, last: 1'b1};
    case (func) inside
      FUNC_INS_FRONT, FUNC_INS_REAR: begin
        if (mirror_count == DEPTH) begin
          beat.status = STAT_FULL;
        end else if (func == FUNC_INS_FRONT) begin
          mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
          mirror_slots[mirror_front] = value;
          mirror_count++;
        end else begin
          mirror_slots[(mirror_front + mirror_count) % DEPTH] = value;
          mirror_count++;
        end
        awaited_beats.push_back(beat);
      end
      FUNC_DEL_FRONT, FUNC_DEL_REAR: begin
        if (mirror_count == 0) begin
          beat.status = STAT_EMPTY;
        end else begin
          if (func == FUNC_DEL_FRONT) mirror_front = (mirror_front + 1) % DEPTH;
          mirror_count--;
        end
        awaited_beats.push_back(beat);
      end
      FUNC_DISPLAY: begin
        if (mirror_count == 0) begin
          beat.status = STAT_EMPTY;
          awaited_beats.push_back(beat);
        end else begin
          for (int i = 0; i < mirror_count; i++) begin
            beat.item     = mirror_slots[(mirror_front + i) % DEPTH];
            beat.has_item = 1'b1;
            beat.last     = (i + 1 == mirror_count);
            awaited_beats.push_back(beat);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7, 0))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      4:       return $urandom_range(255, 0);
      default: return $urandom();
    endcase
  endfunction

  // operation mix depends on whether the run should fill, drain or churn
  function automatic logic [2:0] pick_func(input run_bias_t bias);
    int r;
    r = $urandom_range(99, 0);
    if (r < 4) return 3'($urandom_range(FUNC_SPARE_LAST, FUNC_SPARE_FIRST));
    case (bias)
      BIAS_FILL: begin
        if (r < 42) return FUNC_INS_FRONT;
        if (r < 80) return FUNC_INS_REAR;
        if (r < 87) return FUNC_DEL_FRONT;
        if (r < 94) return FUNC_DEL_REAR;
        return FUNC_DISPLAY;
      end
      BIAS_DRAIN: begin
        if (r < 12) return FUNC_INS_FRONT;
        if (r < 20) return FUNC_INS_REAR;
        if (r < 55) return FUNC_DEL_FRONT;
        if (r < 90) return FUNC_DEL_REAR;
        return FUNC_DISPLAY;
      end
      default: begin
        if (r < 27) return FUNC_INS_FRONT;
        if (r < 50) return FUNC_INS_REAR;
        if (r < 66) return FUNC_DEL_FRONT;
        if (r < 82) return FUNC_DEL_REAR;
        return FUNC_DISPLAY;
      end
    endcase
  endfunction

  task automatic add_cmd(input logic [2:0] func, input logic [31:0] value);
    pending_cmds.push_back('{func: func, value: value});
    cmd_total++;
  endtask

  // input driver: new beat only when the line is free or the last one was taken
  always @(negedge clk) begin : drive_in
    deq_cmd_t cmd;
    if (!rst) begin
      if (!s_tvalid || beat_taken) begin
        if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= send_idle) begin
          cmd = pending_cmds.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= cmd.func;
          s_tdata  <= cmd.value;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      beat_taken = 1'b0;
    end
  end

  // output ready, with one long hold-off on request
  always @(negedge clk) begin : drive_out
    if (!rst) begin
      if (stall_req) begin
        stall_left = LONG_STALL;
        stall_req  = 1'b0;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99, 0) >= recv_idle);
      end
    end
  end

  // monitor: mirror accepted commands, compare output beats
  always @(posedge clk) begin : watch
    deq_beat_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        apply_deque_op(s_tuser, s_tdata);
        beats_in++;
        beat_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (awaited_beats.size() == 0) begin
          $error("unexpected output beat: item %h user %b last %b", m_tdata, m_tuser, m_tlast);
          fail_count++;
        end else begin
          want = awaited_beats.pop_front();
          if (m_tuser[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser[1:0]);
            fail_count++;
          end
          if (m_tdata !== want.item) begin
            $error("item: expected %h, got %h", want.item, m_tdata);
            fail_count++;
          end
          if (m_tuser[2] !== want.has_item) begin
            $error("has_item: expected %0d, got %0d", want.has_item, m_tuser[2]);
            fail_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_tlast);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int        counted;
    int        cnt;
    run_bias_t bias;
    logic [2:0] func;

    // empty-queue corners and unused codes
    add_cmd(FUNC_DISPLAY,   32'h1234_5678);
    add_cmd(FUNC_DEL_FRONT, 32'hffff_ffff);
    add_cmd(FUNC_DEL_REAR,  32'h8000_0000);
    add_cmd(FUNC_SPARE_FIRST, 32'h0000_0001);
    add_cmd(FUNC_SPARE_MID,   32'h5555_5555);
    add_cmd(FUNC_SPARE_LAST,  32'haaaa_aaaa);
    // value extremes, then fill to full from both ends
    add_cmd(FUNC_INS_FRONT, 32'h7fff_ffff);
    add_cmd(FUNC_INS_REAR,  32'h8000_0000);
    add_cmd(FUNC_INS_FRONT, 32'hffff_ffff);
    add_cmd(FUNC_INS_REAR,  32'h0000_0000);
    for (int i = 4; i < DEPTH; i++)
      add_cmd((i % 2) ? FUNC_INS_FRONT : FUNC_INS_REAR, $urandom());
    add_cmd(FUNC_INS_FRONT, 32'hdead_beef);
    add_cmd(FUNC_INS_REAR,  32'hcafe_f00d);
    add_cmd(FUNC_DISPLAY,   32'h0000_0000);
    add_cmd(FUNC_DEL_FRONT, 32'h0000_0000);
    add_cmd(FUNC_DEL_REAR,  32'h0000_0000);

    // random runs, spare codes not counted
    counted = 0;
    cnt     = 0;
    bias    = BIAS_MIXED;
    while (counted < RANDOM_OPS) begin
      if (cnt % RUN_LEN == 0) bias = run_bias_t'($urandom_range(2, 0));
      cnt++;
      func = pick_func(bias);
      add_cmd(func, pick_value());
      if (func <= FUNC_DISPLAY) counted++;
    end

    // reset
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idling phases, long output stall in the last one
    while (beats_in < cmd_total / 3) @(posedge clk);
    send_idle = 79;
    recv_idle = 25;
    while (beats_in < (2 * cmd_total) / 3) @(posedge clk);
    send_idle = 0;
    recv_idle = 0;
    stall_req = 1'b1;

    while (beats_in < cmd_total) @(posedge clk);
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
